// ===== rtl/rotate_translate_point_top_macros.svh =====
// Assertion macros for the rotate/translate point pipeline.
// Included by rotate_translate_point_top; expects clk and rst in scope.
// The SYNTH build gets empty bodies.
`ifndef ROTATE_TRANSLATE_POINT_TOP_MACROS_SVH
`define ROTATE_TRANSLATE_POINT_TOP_MACROS_SVH

`ifndef SYNTH

`define RTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtp: same-cycle check failed");

`define RTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtp: next-cycle check failed");

`else

`define RTP_ASSERT_NOW(lbl, ante, cons)

`define RTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/rtp_pkg.sv =====
// Shared types and constants for the rotate/translate point pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rtp_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // CORDIC datapath: Q1.30 cos/sin, 32-bit turn angle
  localparam int CW         = 32;
  localparam int TURN_W     = 32;
  localparam int GAIN_FRAC  = 30;
  localparam int ATAN_COUNT = 24;

  localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [TURN_W-1:0] ATAN_TURN32 [0:ATAN_COUNT-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic        [ANGLE_WIDTH-1:0] angle;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] result_x;
    logic signed [COORD_WIDTH-1:0] result_y;
    logic                          overflow;
  } result_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
  } pass_t;

  typedef struct packed {
    quad_t              quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    pass_t              pt;
  } trig_t;

endpackage

// ===== rtl/rtp_cordic.sv =====
// Angle split and unrolled CORDIC rotation, one register per iteration.
// Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_cordic import rtp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  output logic   point_ready,
  input  point_t point_data,
  output logic   trig_valid,
  input  logic   trig_ready,
  output trig_t  trig_data
);

  localparam int N = CORDIC_STAGES;

  typedef struct packed {
    quad_t                quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    pass_t                pt;
  } stage_t;

  logic   vld      [0:N];
  logic   rdy      [0:N];
  logic   vld_prev [0:N];
  stage_t stg      [0:N];
  stage_t stg_next [0:N];

  logic [TURN_W-1:0] turn;

  always_comb begin
    turn = {point_data.angle, {(TURN_W-ANGLE_WIDTH){1'b0}}} + TURN_W'(32'h2000_0000);
    stg_next[0].quad = quad_t'(turn[TURN_W-1:TURN_W-2]);
    stg_next[0].x    = GAIN_Q30;
    stg_next[0].y    = '0;
    stg_next[0].z    = $signed({2'b00, turn[TURN_W-3:0]}) - $signed(CW'(32'h2000_0000));
    stg_next[0].pt.px = point_data.point_x;
    stg_next[0].pt.py = point_data.point_y;
    stg_next[0].pt.cx = point_data.center_x;
    stg_next[0].pt.cy = point_data.center_y;
  end

  assign vld_prev[0] = point_valid;
  assign rdy[N]      = !vld[N] || trig_ready;

  genvar k;
  generate
    for (k = 1; k <= N; k++) begin : g_iter
      localparam int Sh = k - 1;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;

      assign dx = $signed(stg[k-1].y) >>> Sh;
      assign dy = $signed(stg[k-1].x) >>> Sh;
      assign at = $signed(ATAN_TURN32[Sh]);
      assign vld_prev[k] = vld[k-1];

      always_comb begin
        stg_next[k] = stg[k-1];
        if (!stg[k-1].z[CW-1]) begin
          stg_next[k].x = stg[k-1].x - dx;
          stg_next[k].y = stg[k-1].y + dy;
          stg_next[k].z = stg[k-1].z - at;
        end else begin
          stg_next[k].x = stg[k-1].x + dx;
          stg_next[k].y = stg[k-1].y - dy;
          stg_next[k].z = stg[k-1].z + at;
        end
      end
    end

    for (k = 0; k < N; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    for (k = 0; k <= N; k++) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld_prev[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          stg[k] <= stg_next[k];
        end
      end
    end
  endgenerate

  assign point_ready    = rdy[0];
  assign trig_valid     = vld[N];
  assign trig_data.quad = stg[N].quad;
  assign trig_data.x    = stg[N].x;
  assign trig_data.y    = stg[N].y;
  assign trig_data.pt   = stg[N].pt;

endmodule

// ===== rtl/rtp_rotate.sv =====
// Quadrant fix-up, rotation products, rounding, offset add and saturation.
// Four register stages. Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_rotate import rtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    trig_valid,
  output logic    trig_ready,
  input  trig_t   trig_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result_data
);

  localparam int PROD_W = COORD_WIDTH + CW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - GAIN_FRAC;
  localparam int OFS_W  = RND_W + 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (GAIN_FRAC - 1));
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    pass_t                pt;
  } fix_t;

  typedef struct packed {
    logic signed [PROD_W-1:0]      pxc;
    logic signed [PROD_W-1:0]      pys;
    logic signed [PROD_W-1:0]      pyc;
    logic signed [PROD_W-1:0]      pxs;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
  } prod_t;

  typedef struct packed {
    logic signed [RND_W-1:0]       rx;
    logic signed [RND_W-1:0]       ry;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
  } rnd_t;

  logic va, vb, vc, vd;
  logic ra, rb, rc, rd;

  fix_t    fix, fix_next;
  prod_t   prod, prod_next;
  rnd_t    rnd, rnd_next;
  result_t res, res_next;

  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [OFS_W-1:0] ofs_x, ofs_y;
  logic                    ovf_x, ovf_y;

  assign rd = !vd || result_ready;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;

  always_comb begin
    fix_next.pt = trig_data.pt;
    case (trig_data.quad)
      QUAD_0: begin
        fix_next.c = trig_data.x;
        fix_next.s = trig_data.y;
      end
      QUAD_1: begin
        fix_next.c = -trig_data.y;
        fix_next.s = trig_data.x;
      end
      QUAD_2: begin
        fix_next.c = -trig_data.x;
        fix_next.s = -trig_data.y;
      end
      QUAD_3: begin
        fix_next.c = trig_data.y;
        fix_next.s = -trig_data.x;
      end
      default: begin
        fix_next.c = trig_data.x;
        fix_next.s = trig_data.y;
      end
    endcase
  end

  always_comb begin
    prod_next.pxc = PROD_W'($signed(fix.pt.px)) * PROD_W'($signed(fix.c));
    prod_next.pys = PROD_W'($signed(fix.pt.py)) * PROD_W'($signed(fix.s));
    prod_next.pyc = PROD_W'($signed(fix.pt.py)) * PROD_W'($signed(fix.c));
    prod_next.pxs = PROD_W'($signed(fix.pt.px)) * PROD_W'($signed(fix.s));
    prod_next.cx  = fix.pt.cx;
    prod_next.cy  = fix.pt.cy;
  end

  always_comb begin
    sum_x = SUM_W'($signed(prod.pxc)) - SUM_W'($signed(prod.pys)) + ROUND_HALF;
    sum_y = SUM_W'($signed(prod.pyc)) + SUM_W'($signed(prod.pxs)) + ROUND_HALF;
    rnd_next.rx = sum_x[SUM_W-1:GAIN_FRAC];
    rnd_next.ry = sum_y[SUM_W-1:GAIN_FRAC];
    rnd_next.cx = prod.cx;
    rnd_next.cy = prod.cy;
  end

  always_comb begin
    ofs_x = OFS_W'($signed(rnd.rx)) + OFS_W'($signed(rnd.cx));
    ofs_y = OFS_W'($signed(rnd.ry)) + OFS_W'($signed(rnd.cy));
    ovf_x = 1'b1;
    ovf_y = 1'b1;
    if (ofs_x > OFS_W'(COORD_MAX)) begin
      res_next.result_x = COORD_MAX;
    end else if (ofs_x < OFS_W'(COORD_MIN)) begin
      res_next.result_x = COORD_MIN;
    end else begin
      res_next.result_x = ofs_x[COORD_WIDTH-1:0];
      ovf_x = 1'b0;
    end
    if (ofs_y > OFS_W'(COORD_MAX)) begin
      res_next.result_y = COORD_MAX;
    end else if (ofs_y < OFS_W'(COORD_MIN)) begin
      res_next.result_y = COORD_MIN;
    end else begin
      res_next.result_y = ofs_y[COORD_WIDTH-1:0];
      ovf_y = 1'b0;
    end
    res_next.overflow = ovf_x || ovf_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (ra) va <= trig_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) fix  <= fix_next;
    if (rb) prod <= prod_next;
    if (rc) rnd  <= rnd_next;
    if (rd) res  <= res_next;
  end

  assign trig_ready   = ra;
  assign result_valid = vd;
  assign result_data  = res;

endmodule

// ===== rtl/rotate_translate_point_top.sv =====
// channel  | valid         | ready         | payload
// point    | point_valid   | point_ready   | point_data  (point_t)
// result   | result_valid  | result_ready  | result_data (result_t)
//
// One point per cycle unless the result side stalls; stages: angle split, 16 CORDIC iterations,
// quadrant fix-up, products, rounding, offset add with saturation.
// Synchronous reset clears all stage valid bits; payload registers are not reset.
// Each stage advances when empty or when the stage after it advances, so a
// stalled result only blocks input once every stage holds an item.
// Top level of the rotate/translate point block.
// Depends on rtp_pkg, rtp_cordic, rtp_rotate and the assertion macro header.
`timescale 1ns / 1ps
`include "rotate_translate_point_top_macros.svh"

module rotate_translate_point_top import rtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    point_valid,
  output logic    point_ready,
  input  point_t  point_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result_data
);

  logic  trig_valid;
  logic  trig_ready;
  trig_t trig_data;

  rtp_cordic u_cordic (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_data  (point_data),
    .trig_valid  (trig_valid),
    .trig_ready  (trig_ready),
    .trig_data   (trig_data)
  );

  rtp_rotate u_rotate (
    .clk          (clk),
    .rst          (rst),
    .trig_valid   (trig_valid),
    .trig_ready   (trig_ready),
    .trig_data    (trig_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  localparam logic signed [COORD_WIDTH-1:0] SAT_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  `RTP_ASSERT_NOW(a_ovf_clamped, result_valid && result_data.overflow,
    result_data.result_x == SAT_HI || result_data.result_x == SAT_LO ||
    result_data.result_y == SAT_HI || result_data.result_y == SAT_LO)
  `RTP_ASSERT_NOW(a_backpressure_src, !point_ready, result_valid && !result_ready)
  `RTP_ASSERT_NOW(a_mid_stall_src, trig_valid && !trig_ready, result_valid && !result_ready)
  `RTP_ASSERT_NEXT(a_full_holds, !point_ready && !result_ready, result_valid && $stable(result_data))

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for rotate_translate_point_top: a directed table of points, then
// random points, checked against set results or a bit-exact CORDIC rotate-and-offset model.
// Depends on rtp_pkg and the rotate_translate_point_top RTL.
`timescale 1ns / 1ps

module tb;
  import rtp_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [ANGLE_WIDTH-1:0] angle_t;

  typedef struct {
    point_t  pt;
    bit      known;
    result_t res;
  } point_case_t;

  localparam int     FRAC          = 16;
  localparam int     RANDOM_POINTS = 1230;
  localparam int     HOLD_CYCLES   = 150;
  localparam int     DRAIN_CYCLES  = 40;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     MAX_PRINTS    = 25;
  localparam coord_t MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t ONE  = coord_t'(1) <<< FRAC;

  localparam logic signed [95:0] HALF_Q30 = 96'sh2000_0000;

  localparam longint UNIT_GAIN = 652032874;
  localparam int     ARC_N     = 24;
  localparam longint ARC_TURN [0:ARC_N-1] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  logic    clk;
  logic    rst;
  logic    point_valid;
  logic    point_ready;
  point_t  point_data;
  logic    result_valid;
  logic    result_ready;
  result_t result_data;

  point_case_t dir_rows[$];
  point_case_t in_flight[$];
  result_t     due_results[$];

  int mismatches   = 0;
  int results_seen = 0;
  int points_sent  = 0;
  int saturated    = 0;
  int backed_up    = 0;
  int cycles       = 0;

  rotate_translate_point_top u_top (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point_data   (point_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic coord_t clamp_coord(input logic signed [95:0] v, inout bit ovf);
    if (v > MAXC) begin
      ovf = 1'b1;
      return MAXC;
    end
    if (v < MINC) begin
      ovf = 1'b1;
      return MINC;
    end
    return coord_t'(v);
  endfunction

  function automatic result_t rotate_and_offset(input point_t p);
    logic [31:0]        turn;
    quad_t              quad;
    longint             x, y, z, dx, dy, c, s, px, py;
    logic signed [95:0] acc_x, acc_y;
    bit                 ovf;
    result_t            r;
    turn = (32'(p.angle) << (32 - ANGLE_WIDTH)) + 32'h2000_0000;
    quad = quad_t'(turn[31:30]);
    z    = longint'({2'b00, turn[29:0]}) - 64'sh2000_0000;
    x    = UNIT_GAIN;
    y    = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= (i < ARC_N) ? ARC_TURN[i] : longint'(0);
      end else begin
        x += dx;
        y -= dy;
        z += (i < ARC_N) ? ARC_TURN[i] : longint'(0);
      end
    end
    case (quad)
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    px    = p.point_x;
    py    = p.point_y;
    acc_x = (96'(px) * 96'(c) - 96'(py) * 96'(s) + HALF_Q30) >>> 30;
    acc_y = (96'(py) * 96'(c) + 96'(px) * 96'(s) + HALF_Q30) >>> 30;
    acc_x = acc_x + 96'(p.center_x);
    acc_y = acc_y + 96'(p.center_y);
    ovf   = 1'b0;
    r.result_x = clamp_coord(acc_x, ovf);
    r.result_y = clamp_coord(acc_y, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic point_t mk_point(input coord_t x, input coord_t y, input angle_t a,
                                      input coord_t cx, input coord_t cy);
    point_t p;
    p.point_x  = x;
    p.point_y  = y;
    p.angle    = a;
    p.center_x = cx;
    p.center_y = cy;
    return p;
  endfunction

  function automatic void add_known(input point_t p, input coord_t rx, input coord_t ry,
                                    input logic ovf);
    point_case_t pc;
    pc.pt             = p;
    pc.known          = 1'b1;
    pc.res.result_x   = rx;
    pc.res.result_y   = ry;
    pc.res.overflow   = ovf;
    dir_rows.push_back(pc);
  endfunction

  function automatic void add_free(input point_t p);
    point_case_t pc;
    pc.pt    = p;
    pc.known = 1'b0;
    pc.res   = '0;
    dir_rows.push_back(pc);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5, 6, 7, 8: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return MAXC;
          1: return MINC;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic angle_t rand_angle();
    angle_t octant;
    if ($urandom_range(0, 3) != 0) return angle_t'($urandom);
    octant = angle_t'($urandom_range(0, 7)) << (ANGLE_WIDTH - 3);
    return octant + angle_t'($urandom_range(0, 2)) - angle_t'(1);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
               what, results_seen, got, want);
  endtask

  task automatic send_point(input point_case_t pc, input bit calm);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_flight.push_back(pc);
    point_valid <= 1'b1;
    point_data  <= pc.pt;
    do @(posedge clk); while (!point_ready);
  endtask

  // Track every transfer on both channels and check results in order.
  always @(posedge clk) begin
    point_case_t pc;
    result_t     want;
    if (!rst) begin
      if (point_valid && !point_ready) backed_up++;
      if (point_valid && point_ready) begin
        pc = in_flight.pop_front();
        due_results.push_back(pc.known ? pc.res : rotate_and_offset(point_data));
        points_sent++;
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", longint'(result_data.result_x), 0);
        end else begin
          want = due_results.pop_front();
          if (want.overflow) saturated++;
          if (result_data.result_x !== want.result_x)
            report_mismatch("result_x", longint'(result_data.result_x),
                            longint'(want.result_x));
          if (result_data.result_y !== want.result_y)
            report_mismatch("result_y", longint'(result_data.result_y),
                            longint'(want.result_y));
          if (result_data.overflow !== want.overflow)
            report_mismatch("overflow", longint'(result_data.overflow),
                            longint'(want.overflow));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch of steady acceptance.
  initial begin
    int hold_cnt;
    bit held;
    hold_cnt = 0;
    held     = 1'b0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (!held && results_seen >= 200) begin
        held     = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end else if ((results_seen < 700 || results_seen >= 900) && $urandom_range(0, 3) == 0) begin
        hold_cnt = pick_gap();
      end
      result_ready <= (hold_cnt == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timed out with %0d results still due", due_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    point_case_t pc;
    rst         <= 1'b1;
    point_valid <= 1'b0;
    point_data  <= '0;

    add_known(mk_point('0, '0, 16'h0000, '0, '0), '0, '0, 1'b0);
    add_known(mk_point('0, '0, 16'h1234, MAXC, MINC), MAXC, MINC, 1'b0);
    add_known(mk_point(MAXC, MAXC, 16'h0000, MAXC, MAXC), MAXC, MAXC, 1'b1);
    add_known(mk_point(MINC, MINC, 16'h0000, MINC, MINC), MINC, MINC, 1'b1);
    add_known(mk_point(MAXC, MAXC, 16'h8000, MINC, MINC), MINC, MINC, 1'b1);
    add_free(mk_point(ONE, '0, 16'h0000, '0, '0));
    add_free(mk_point(ONE, '0, 16'h0001, '0, '0));
    add_free(mk_point(ONE, '0, 16'h1FFF, '0, '0));
    add_free(mk_point(ONE, '0, 16'h2000, '0, '0));
    add_free(mk_point(ONE, '0, 16'h4000, '0, '0));
    add_free(mk_point(ONE, '0, 16'h6000, '0, '0));
    add_free(mk_point(ONE, '0, 16'h8000, '0, '0));
    add_free(mk_point(ONE, '0, 16'hA000, '0, '0));
    add_free(mk_point(ONE, '0, 16'hC000, '0, '0));
    add_free(mk_point(ONE, '0, 16'hE000, '0, '0));
    add_free(mk_point(ONE, '0, 16'hFFFF, '0, '0));
    add_free(mk_point('0, ONE, 16'h4000, -ONE, ONE));
    add_free(mk_point(MINC, '0, 16'h8000, '0, '0));
    add_free(mk_point(MINC, MINC, 16'h4000, '0, '0));
    add_free(mk_point(MAXC, MINC, 16'h2000, '0, '0));
    add_free(mk_point(-coord_t'(1), -coord_t'(1), 16'hFFFF, -coord_t'(1), -coord_t'(1)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_point(dir_rows[k], 1'b0);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      pc.pt    = mk_point(rand_coord(), rand_coord(), rand_angle(), rand_coord(), rand_coord());
      pc.known = 1'b0;
      pc.res   = '0;
      send_point(pc, n >= 500 && n < 700);
    end
    point_valid <= 1'b0;

    while (due_results.size() != 0 || in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d points (%0d from the directed table), %0d results checked, %0d saturated",
             points_sent, dir_rows.size(), results_seen, saturated);
    $display("tb: input backed up for %0d cycles, including one %0d-cycle receiver hold-off",
             backed_up, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rtp_pkg.sv
rtl/rtp_cordic.sv
rtl/rtp_rotate.sv
rtl/rotate_translate_point_top.sv
verif/tb.sv
